### rtl/u8cp_pkg.sv
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types, constants and the code point mapping of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8cp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 11;
   localparam int unsigned PAYLOAD_W = 5;
   localparam int unsigned SKIP_W    = 3;
   localparam int unsigned CONT_W    = 6;

   localparam logic [BYTE_W-1:0]    REPLACEMENT_RESET = 8'h3F;
   localparam logic [SKIP_W-1:0]    MAX_SKIP          = 3'd4;
   localparam logic [BYTE_W-1:0]    NO_MAPPING        = 8'h00;
   localparam logic [PAYLOAD_W-1:0] LEAD_MASK         = 5'h1F;
   localparam logic [CONT_W-1:0]    CONT_MASK         = 6'h3F;

   // turkish code points and their display codes
   localparam logic [CP_W-1:0] CP_C_CEDILLA_LC = 11'h0E7;
   localparam logic [CP_W-1:0] CP_G_BREVE_LC   = 11'h11F;
   localparam logic [CP_W-1:0] CP_DOTLESS_I    = 11'h131;
   localparam logic [CP_W-1:0] CP_O_UMLAUT_LC  = 11'h0F6;
   localparam logic [CP_W-1:0] CP_S_CEDILLA_LC = 11'h15F;
   localparam logic [CP_W-1:0] CP_U_UMLAUT_LC  = 11'h0FC;
   localparam logic [CP_W-1:0] CP_C_CEDILLA_UC = 11'h0C7;
   localparam logic [CP_W-1:0] CP_DOTTED_I_UC  = 11'h130;
   localparam logic [CP_W-1:0] CP_G_BREVE_UC   = 11'h11E;
   localparam logic [CP_W-1:0] CP_O_UMLAUT_UC  = 11'h0D6;
   localparam logic [CP_W-1:0] CP_S_CEDILLA_UC = 11'h15E;
   localparam logic [CP_W-1:0] CP_U_UMLAUT_UC  = 11'h0DC;

   localparam logic [BYTE_W-1:0] CODE_C_CEDILLA_LC = 8'h81;
   localparam logic [BYTE_W-1:0] CODE_G_BREVE_LC   = 8'h82;
   localparam logic [BYTE_W-1:0] CODE_DOTLESS_I    = 8'h83;
   localparam logic [BYTE_W-1:0] CODE_O_UMLAUT_LC  = 8'h84;
   localparam logic [BYTE_W-1:0] CODE_S_CEDILLA_LC = 8'h85;
   localparam logic [BYTE_W-1:0] CODE_U_UMLAUT_LC  = 8'h86;
   localparam logic [BYTE_W-1:0] CODE_C_CEDILLA_UC = 8'h87;
   localparam logic [BYTE_W-1:0] CODE_DOTTED_I_UC  = 8'h88;
   localparam logic [BYTE_W-1:0] CODE_G_BREVE_UC   = 8'h89;
   localparam logic [BYTE_W-1:0] CODE_O_UMLAUT_UC  = 8'h8A;
   localparam logic [BYTE_W-1:0] CODE_S_CEDILLA_UC = 8'h8B;
   localparam logic [BYTE_W-1:0] CODE_U_UMLAUT_UC  = 8'h8C;

   typedef logic [BYTE_W-1:0] byte_type;

   function automatic byte_type map_code_point(input logic [CP_W-1:0] cp);
      byte_type code;
      case (cp)
         CP_C_CEDILLA_LC: code = CODE_C_CEDILLA_LC;
         CP_G_BREVE_LC:   code = CODE_G_BREVE_LC;
         CP_DOTLESS_I:    code = CODE_DOTLESS_I;
         CP_O_UMLAUT_LC:  code = CODE_O_UMLAUT_LC;
         CP_S_CEDILLA_LC: code = CODE_S_CEDILLA_LC;
         CP_U_UMLAUT_LC:  code = CODE_U_UMLAUT_LC;
         CP_C_CEDILLA_UC: code = CODE_C_CEDILLA_UC;
         CP_DOTTED_I_UC:  code = CODE_DOTTED_I_UC;
         CP_G_BREVE_UC:   code = CODE_G_BREVE_UC;
         CP_O_UMLAUT_UC:  code = CODE_O_UMLAUT_UC;
         CP_S_CEDILLA_UC: code = CODE_S_CEDILLA_UC;
         CP_U_UMLAUT_UC:  code = CODE_U_UMLAUT_UC;
         default:         code = NO_MAPPING;
      endcase
      return code;
   endfunction

   // remaining bytes of a sequence, leading ones capped at five, minus one, never below zero
   function automatic logic [SKIP_W-1:0] lead_extra(input byte_type b);
      logic [SKIP_W-1:0] n;
      if (!b[7] || !b[6]) begin
         n = 3'd0;
      end else if (!b[5]) begin
         n = 3'd1;
      end else if (!b[4]) begin
         n = 3'd2;
      end else if (!b[3]) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

endpackage

### rtl/u8cp_req_if.sv
// ----------------------------------------------------------------------------
// u8cp_req_if
// Byte input channel of the UTF-8 decoder: valid, ready and one text byte.
// ----------------------------------------------------------------------------
interface u8cp_req_if;
   logic                       valid;
   logic                       ready;
   logic [u8cp_pkg::BYTE_W-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/u8cp_rsp_if.sv
// ----------------------------------------------------------------------------
// u8cp_rsp_if
// Character output channel of the UTF-8 decoder: valid, ready and one code.
// ----------------------------------------------------------------------------
interface u8cp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [u8cp_pkg::BYTE_W-1:0] char_code;
   logic                       was_replaced;

   modport source (output valid, output char_code, output was_replaced, input ready);
   modport sink   (input valid, input char_code, input was_replaced, output ready);
endinterface

### rtl/utf8_to_codepage_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_codepage_decoder
// Path: input reg, then result reg, from byte accept to character valid.
// Throughput: one byte per cycle unless a held result stalls the output.
// Reset: synchronous; clears pipeline valids and decode state, and loads the
// replacement code register with '?'.
// ----------------------------------------------------------------------------
module utf8_to_codepage_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [u8cp_pkg::BYTE_W-1:0] csr_wr_data,
   u8cp_req_if.sink                    req_if,
   u8cp_rsp_if.source                  rsp_if
);
   import u8cp_pkg::*;

   byte_type                 repl_ff;
   logic                     s1_valid_ff;
   byte_type                 s1_byte_ff;
   logic                     s1_last_ff;
   logic [SKIP_W-1:0]        skip_ff,    skip_in;
   logic                     await_ff,   await_in;
   logic [PAYLOAD_W-1:0]     payload_ff, payload_in;
   logic                     s2_valid_ff;
   byte_type                 s2_code_ff, s2_code_in;
   logic                     s2_repl_ff, s2_repl_in;
   logic                     s2_load;
   logic                     s1_adv;
   logic                     s2_free;
   logic [SKIP_W-1:0]        extra;
   byte_type                 mapped;

   assign s2_free      = !s2_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && s2_free;
   assign req_if.ready = !s1_valid_ff || s2_free;

   assign extra  = lead_extra(s1_byte_ff);
   assign mapped = map_code_point({payload_ff, s1_byte_ff[CONT_W-1:0] & CONT_MASK});

   always_comb begin
      skip_in    = skip_ff;
      await_in   = await_ff;
      payload_in = payload_ff;
      s2_load    = 1'b0;
      s2_code_in = s1_byte_ff;
      s2_repl_in = 1'b0;
      if (skip_ff != '0) begin
         skip_in = skip_ff - 3'd1;
      end else if (await_ff) begin
         await_in = 1'b0;
         s2_load  = 1'b1;
         if (mapped != NO_MAPPING) begin
            s2_code_in = mapped;
         end else begin
            s2_code_in = repl_ff;
            s2_repl_in = 1'b1;
         end
      end else if (extra == 3'd0) begin
         s2_load = 1'b1;
      end else if (extra == 3'd1) begin
         if (!s1_last_ff) begin
            await_in   = 1'b1;
            payload_in = s1_byte_ff[PAYLOAD_W-1:0] & LEAD_MASK;
         end
      end else begin
         s2_load    = 1'b1;
         s2_code_in = repl_ff;
         s2_repl_in = 1'b1;
         skip_in    = extra;
      end
      // end of text drops whatever is pending
      if (s1_last_ff) begin
         skip_in    = '0;
         await_in   = 1'b0;
         payload_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff     <= REPLACEMENT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         skip_ff     <= '0;
         await_ff    <= 1'b0;
         payload_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            repl_ff <= csr_wr_data;
         end
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_adv) begin
            skip_ff    <= skip_in;
            await_ff   <= await_in;
            payload_ff <= payload_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_adv && s2_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_byte_ff <= req_if.data_byte;
         s1_last_ff <= req_if.last_byte;
      end
      if (s1_adv && s2_load) begin
         s2_code_ff <= s2_code_in;
         s2_repl_ff <= s2_repl_in;
      end
   end

   assign rsp_if.valid        = s2_valid_ff;
   assign rsp_if.char_code    = s2_code_ff;
   assign rsp_if.was_replaced = s2_repl_ff;

`ifndef SYNTHESIS
   a_skip_range: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= MAX_SKIP)
      else $error("skip count out of range");

   a_skip_await_excl: assert property (@(posedge clock) disable iff (reset)
      !(await_ff && skip_ff != '0))
      else $error("skip and second-byte wait both pending");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> skip_ff == '0 && !await_ff && payload_ff == '0)
      else $error("state not cleared after final byte");

   a_no_result_while_skipping: assert property (@(posedge clock) disable iff (reset)
      s1_adv && skip_ff != '0 |=> !$rose(s2_valid_ff))
      else $error("result produced for a skipped byte");
`endif

endmodule
